// File: hdl/hkrb_pkg.sv
// ----------------------------------------------------------------------------
// hkrb_pkg: shared types and constants of the keyboard report builder
// Key event codes, the controller-to-datapath command and status structs and
// the fixed ASCII-to-usage table.
// ----------------------------------------------------------------------------
`default_nettype none

package hkrb_pkg;

	localparam int NUM_SLOTS = 6;

	// Key code ranges and report bits
	localparam logic [7:0] RAW_BASE   = 8'd136;
	localparam logic [7:0] LEFT_SHIFT = 8'h02;

	// Key event kinds carried in the low bits of the input request
	typedef enum logic [1:0] {
		FUNC_PRESS       = 2'd0,
		FUNC_RELEASE     = 2'd1,
		FUNC_RELEASE_ALL = 2'd2,
		FUNC_WRITE       = 2'd3
	} func_t;

	// Controller to datapath
	typedef struct packed {
		logic  capture; // take a new request into the item register
		logic  exec;    // perform op on the report and load the output register
		func_t op;      // press, release or release all
		logic  last;    // last result of the current request
	} hkrb_cmd_t;

	// Datapath to controller
	typedef struct packed {
		func_t func;    // kind of the request held in the item register
	} hkrb_status_t;

	// ASCII to usage table; bit 7 marks a character that needs left shift.
	localparam logic [7:0] ASCII_ROM [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
		8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
		8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
		8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
		8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
	};

endpackage

`default_nettype wire

// File: hdl/hkrb_ctrl.sv
// ----------------------------------------------------------------------------
// hkrb_ctrl: sequencing controller of the keyboard report builder
// Accepts one request at a time, issues one or two report operations for it
// and keeps the valid flag of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrb_ctrl
	import hkrb_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	input  wire hkrb_status_t status,
	output hkrb_cmd_t         cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_REL  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register may be reloaded when empty or being emptied.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.op      = FUNC_PRESS;
		cmd.last    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// A write starts as a press and is finished by a release.
				cmd.op   = (status.func == FUNC_WRITE) ? FUNC_PRESS : status.func;
				cmd.last = (status.func != FUNC_WRITE);
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = (status.func == FUNC_WRITE) ? ST_REL : ST_IDLE;
				end
			end
			ST_REL: begin
				cmd.op = FUNC_RELEASE;
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/hkrb_dpath.sv
// ----------------------------------------------------------------------------
// hkrb_dpath: report state and key handling of the keyboard report builder
// Holds the modifier byte and six key slots, decodes the key code and applies
// press, release and release all; the outcome lands in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkrb_dpath
	import hkrb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire hkrb_cmd_t   cmd,
	output hkrb_status_t     status,
	input  wire logic [1:0]  in_func,
	input  wire logic [7:0]  in_key_code,
	output logic      [55:0] out_report,
	output logic             out_sent,
	output logic             out_success,
	output logic             out_last
);

	// Item register
	func_t       func_q;
	logic [7:0]  code_q;

	// Report state
	logic [7:0]  mod_q;
	logic [7:0]  slots_q [NUM_SLOTS];

	// Next report state and outcome
	logic [7:0]  mod_d;
	logic [7:0]  slots_d [NUM_SLOTS];
	logic        ok;

	// Key decode
	logic [7:0]  rom_entry;
	logic [7:0]  usage;
	logic [7:0]  mod_mask;
	logic        mapped;

	assign status.func = func_q;

	always_comb begin
		rom_entry = ASCII_ROM[code_q[6:0]];
		usage     = '0;
		mod_mask  = '0;
		mapped    = 1'b1;
		if (code_q >= RAW_BASE) begin
			usage = code_q - RAW_BASE;
		end else if (code_q[7]) begin
			mod_mask = 8'd1 << code_q[2:0];
		end else if (rom_entry == '0) begin
			mapped = 1'b0;
		end else begin
			usage = {1'b0, rom_entry[6:0]};
			if (rom_entry[7]) begin
				mod_mask = LEFT_SHIFT;
			end
		end
	end

	always_comb begin
		logic present;
		logic placed;
		mod_d   = mod_q;
		slots_d = slots_q;
		ok      = 1'b1;
		present = 1'b0;
		placed  = 1'b0;
		case (cmd.op)
			FUNC_PRESS: begin
				if (!mapped) begin
					ok = 1'b0;
				end else begin
					mod_d = mod_q | mod_mask;
					// A usage of zero counts as present whenever a slot is empty.
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (slots_q[i] == usage) begin
							present = 1'b1;
						end
					end
					if (!present) begin
						for (int i = 0; i < NUM_SLOTS; i++) begin
							if (!placed && slots_q[i] == '0) begin
								slots_d[i] = usage;
								placed     = 1'b1;
							end
						end
						ok = placed;
					end
				end
			end
			FUNC_RELEASE: begin
				if (!mapped) begin
					ok = 1'b0;
				end else begin
					mod_d = mod_q & ~mod_mask;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (usage != '0 && slots_q[i] == usage) begin
							slots_d[i] = '0;
						end
					end
				end
			end
			FUNC_RELEASE_ALL: begin
				mod_d = '0;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					slots_d[i] = '0;
				end
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			mod_q   <= mod_d;
			slots_q <= slots_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(in_func);
			code_q <= in_key_code;
		end
		if (cmd.exec) begin
			out_report[7:0] <= mod_d;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				out_report[8*i+8 +: 8] <= slots_d[i];
			end
			out_sent    <= ok;
			out_success <= ok;
			out_last    <= cmd.last;
		end
	end

endmodule

`default_nettype wire

// File: hdl/hid_keyboard_report_builder.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder: boot keyboard report builder, six-key rollover
// Applies key events to a report of one modifier byte and six key slots and
// delivers the report after every attempted action.
// ----------------------------------------------------------------------------
// Usage. Key events arrive as requests on the s_ stream: func in the low two
// bits (press, release, release all, write) and the key code above it. Each
// action yields a report request on the m_ stream with the modifier byte and
// the six slots in m_tdata, the sent and success flags in m_tuser and m_tlast
// marking the final report of the event. A write yields two reports, the
// press and then the release.
// Timing. An accepted event is captured into the item register and applied
// once the output register is free; a write applies its press, then its
// release. A new event is taken only after the last one is fully applied,
// while its last report may still wait in the output register. The pace is
// set by the controller, which applies each action to the shared report state.
// Stalls. If m_tready is low the finished report holds, the next action waits
// for the output register to empty and s_tready stays low meanwhile.
// Reset. arst_n clears the modifiers, empties every slot and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_builder
	import hkrb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Key event requests
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // func[1:0], key_code[9:2], zero[15:10]
	// Report requests
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [55:0] m_tdata,  // modifier_bits[7:0], slot_zero .. slot_five
	                                   // at [15:8] .. [55:48]
	output logic       [1:0] m_tuser,  // report_sent[0], success[1]
	output logic             m_tlast   // last_of_run
);

	hkrb_cmd_t    cmd;
	hkrb_status_t status;

	// The controller only sequences; all report state lives in the datapath.
	hkrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The upper six bits of s_tdata are padding and are not looked at.
	hkrb_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.in_func     (s_tdata[1:0]),
		.in_key_code (s_tdata[9:2]),
		.out_report  (m_tdata),
		.out_sent    (m_tuser[0]),
		.out_success (m_tuser[1]),
		.out_last    (m_tlast)
	);

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the six-key keyboard report builder
// Key events go in on the s_ stream and reports come out on the m_ stream.
// A behavioural copy of the report state works out each expected report as
// its event is accepted. Every report that leaves the block is compared,
// field by field, with the oldest one still waiting. Both sides idle and stall
// at random throughout the run.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
	import hkrb_pkg::*;
();

	// Key code bases and the flag in the character table that asks for shift.
	localparam logic [7:0] MOD_CODE_BASE = 8'd128;
	localparam logic [7:0] SH            = 8'h80;

	// The watchdog limit is reckoned from the slowest correct pace. A sender
	// gap and a receiver stall, each at most the longest draw_wait, and the
	// block's own work bound the run of cycles without a request. The limit
	// is ten times that bound.
	localparam int IDLE_LIMIT    = 400;
	localparam int RANDOM_EVENTS = 1250;
	localparam int DRAIN_CYCLES  = 8;

	// One report as the block delivers it. keys[i] holds slot i, so the
	// packed vector lines up with m_tdata[55:8].
	typedef struct packed {
		logic [7:0]      mods;
		logic [5:0][7:0] keys;
		logic            sent;
		logic            ok;
		logic            last;
	} report_t;

	// One row of the directed table. Where typed is set, want is the report
	// to expect; the other rows are left to the behavioural model.
	typedef struct packed {
		func_t      f;
		logic [7:0] code;
		logic       typed;
		report_t    want;
	} stim_row_t;

	localparam report_t ANY = '0;

	// Character to usage table, typed in from the keyboard layout. Bit 7 marks
	// a character that needs left shift.
	localparam logic [7:0] KEY_USAGE [128] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h2c, 8'h1e | SH, 8'h34 | SH, 8'h20 | SH,
		8'h21 | SH, 8'h22 | SH, 8'h24 | SH, 8'h34,
		8'h26 | SH, 8'h27 | SH, 8'h25 | SH, 8'h2e | SH,
		8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'h33 | SH, 8'h33, 8'h36 | SH, 8'h2e, 8'h37 | SH, 8'h38 | SH,
		8'h1f | SH, 8'h04 | SH, 8'h05 | SH, 8'h06 | SH,
		8'h07 | SH, 8'h08 | SH, 8'h09 | SH, 8'h0a | SH,
		8'h0b | SH, 8'h0c | SH, 8'h0d | SH, 8'h0e | SH,
		8'h0f | SH, 8'h10 | SH, 8'h11 | SH, 8'h12 | SH,
		8'h13 | SH, 8'h14 | SH, 8'h15 | SH, 8'h16 | SH,
		8'h17 | SH, 8'h18 | SH, 8'h19 | SH, 8'h1a | SH,
		8'h1b | SH, 8'h1c | SH, 8'h1d | SH, 8'h2f,
		8'h31, 8'h30, 8'h23 | SH, 8'h2d | SH,
		8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
		8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
		8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
		8'h1b, 8'h1c, 8'h1d, 8'h2f | SH, 8'h31 | SH, 8'h30 | SH, 8'h35 | SH, 8'h00
	};

	// Directed events. They start from an empty report, fill all six slots,
	// then try to press into the full report, release a key that carries no
	// usage, write and clear everything again. Codes 0 and 255 between them
	// drive every bit of the key code both ways.
	localparam int NUM_DIRECTED = 25;
	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{FUNC_RELEASE_ALL, 8'd0,   1'b1, '{8'h00, 48'h0,  1'b1, 1'b1, 1'b1}},
		'{FUNC_PRESS,       8'd0,   1'b1, '{8'h00, 48'h0,  1'b0, 1'b0, 1'b1}},
		'{FUNC_RELEASE,     8'd127, 1'b1, '{8'h00, 48'h0,  1'b0, 1'b0, 1'b1}},
		'{FUNC_PRESS,       8'h61,  1'b1, '{8'h00, 48'h04, 1'b1, 1'b1, 1'b1}},
		'{FUNC_PRESS,       8'h41,  1'b0, ANY},
		'{FUNC_PRESS,       8'd128, 1'b0, ANY},
		'{FUNC_PRESS,       8'd135, 1'b0, ANY},
		'{FUNC_PRESS,       8'd136, 1'b0, ANY},
		'{FUNC_PRESS,       8'd255, 1'b0, ANY},
		'{FUNC_PRESS,       8'd137, 1'b0, ANY},
		'{FUNC_PRESS,       8'd138, 1'b0, ANY},
		'{FUNC_PRESS,       8'd139, 1'b0, ANY},
		'{FUNC_PRESS,       8'd141, 1'b0, ANY},
		'{FUNC_PRESS,       8'd142, 1'b0, ANY},
		'{FUNC_PRESS,       8'h21,  1'b0, ANY},
		'{FUNC_PRESS,       8'd136, 1'b0, ANY},
		'{FUNC_RELEASE,     8'd136, 1'b0, ANY},
		'{FUNC_RELEASE,     8'd255, 1'b0, ANY},
		'{FUNC_WRITE,       8'h7a,  1'b0, ANY},
		'{FUNC_WRITE,       8'h0a,  1'b0, ANY},
		'{FUNC_RELEASE,     8'd128, 1'b0, ANY},
		'{FUNC_WRITE,       8'd200, 1'b0, ANY},
		'{FUNC_RELEASE_ALL, 8'd255, 1'b1, '{8'h00, 48'h0,  1'b1, 1'b1, 1'b1}},
		'{FUNC_WRITE,       8'h1b,  1'b0, ANY},
		'{FUNC_WRITE,       8'h08,  1'b0, ANY}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // func[1:0], key_code[9:2], zero[15:10]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // modifier_bits[7:0], slot_zero .. slot_five at [15:8] .. [55:48]
	logic  [1:0] m_tuser;   // report_sent[0], success[1]
	logic        m_tlast;   // last_of_run

	// Behavioural copy of the report held by the block.
	logic [7:0]      mod_state;
	logic [5:0][7:0] key_state;

	// Reports worked out at acceptance and not yet seen on the output.
	report_t pending_reports [$];

	// The counters start at zero and each has a single writer.
	int  mismatches;
	int  reports_seen;
	int  idle_cycles;
	bit  no_idle;

	hid_keyboard_report_builder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Behavioural model of the report
	// ------------------------------------------------------------------------

	// Applies a key press to the model. Returns 1 when the press succeeds.
	// A modifier or shift bit is set before the slot search, so it stays set
	// even when the report turns out to be full.
	function automatic bit press_key(logic [7:0] code);
		logic [7:0] usage;
		bit         present;
		bit         placed;
		int         i;
		present = 1'b0;
		placed  = 1'b0;
		if (code >= RAW_BASE) begin
			usage = code - RAW_BASE;
		end else if (code >= MOD_CODE_BASE) begin
			mod_state[code[2:0]] = 1'b1;
			usage = 8'h00;
		end else begin
			usage = KEY_USAGE[code[6:0]];
			if (usage == 8'h00)
				return 1'b0;
			if (usage[7]) begin
				mod_state = mod_state | LEFT_SHIFT;
				usage[7]  = 1'b0;
			end
		end
		// Usage zero counts as present whenever a slot is empty, so a bare
		// modifier press only fails on a full report.
		for (i = 0; i < NUM_SLOTS; i++)
			if (key_state[i] == usage)
				present = 1'b1;
		if (present)
			return 1'b1;
		for (i = 0; i < NUM_SLOTS; i++) begin
			if (!placed && key_state[i] == 8'h00) begin
				key_state[i] = usage;
				placed       = 1'b1;
			end
		end
		return placed;
	endfunction

	// Applies a key release. Every slot holding the usage is cleared; usage
	// zero clears nothing. Only an unmapped character fails.
	function automatic bit release_key(logic [7:0] code);
		logic [7:0] usage;
		int         i;
		if (code >= RAW_BASE) begin
			usage = code - RAW_BASE;
		end else if (code >= MOD_CODE_BASE) begin
			mod_state[code[2:0]] = 1'b0;
			usage = 8'h00;
		end else begin
			usage = KEY_USAGE[code[6:0]];
			if (usage == 8'h00)
				return 1'b0;
			if (usage[7]) begin
				mod_state = mod_state & ~LEFT_SHIFT;
				usage[7]  = 1'b0;
			end
		end
		for (i = 0; i < NUM_SLOTS; i++)
			if (usage != 8'h00 && key_state[i] == usage)
				key_state[i] = 8'h00;
		return 1'b1;
	endfunction

	function automatic report_t snapshot(bit ok, bit last);
		return '{mods: mod_state, keys: key_state, sent: ok, ok: ok, last: last};
	endfunction

	// Works out the reports of one accepted key event and queues them.
	function automatic void apply_event(func_t f, logic [7:0] code);
		bit ok;
		case (f)
			FUNC_PRESS: begin
				ok = press_key(code);
				pending_reports.push_back(snapshot(ok, 1'b1));
			end
			FUNC_RELEASE: begin
				ok = release_key(code);
				pending_reports.push_back(snapshot(ok, 1'b1));
			end
			FUNC_RELEASE_ALL: begin
				mod_state = 8'h00;
				key_state = '0;
				pending_reports.push_back(snapshot(1'b1, 1'b1));
			end
			default: begin
				// A write is a press report followed by a release report,
				// each with its own flags.
				ok = press_key(code);
				pending_reports.push_back(snapshot(ok, 1'b0));
				ok = release_key(code);
				pending_reports.push_back(snapshot(ok, 1'b1));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Random draws
	// ------------------------------------------------------------------------

	// Wait before the next request on either side. At least half the draws
	// are zero, and during a calm stretch nobody idles at all.
	function automatic int draw_wait();
		if (no_idle || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Random key events. Half the codes come from a small pool of raw usages
	// and modifiers, so that presses fill the report and later releases find
	// their keys again; the rest are any character or any raw code.
	task automatic draw_event(output func_t f, output logic [7:0] code);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			f = FUNC_PRESS;
		else if (pick < 70)
			f = FUNC_RELEASE;
		else if (pick < 96)
			f = FUNC_WRITE;
		else
			f = FUNC_RELEASE_ALL;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			code = 8'($urandom_range(0, 127));
		else if (pick < 55)
			code = MOD_CODE_BASE + 8'($urandom_range(0, 7));
		else if (pick < 90)
			code = RAW_BASE + 8'($urandom_range(0, 11));
		else
			code = 8'($urandom_range(136, 255));
	endtask

	// Calm stretches: now and then both sides run without any idling.
	initial begin
		no_idle = 1'b0;
		forever begin
			repeat (200) @(posedge clk);
			no_idle = ($urandom_range(0, 3) == 0);
		end
	end

	// ------------------------------------------------------------------------
	// Key event side
	// ------------------------------------------------------------------------

	// Offers one key event and returns at the edge that accepts it. Called at
	// a rising edge; tvalid is only lowered when a gap is drawn, so a request
	// that follows back to back keeps tvalid high.
	task automatic send_event(func_t f, logic [7:0] code);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, code, f};
		do
			@(posedge clk);
		while (!s_tready);
		apply_event(f, code);
	endtask

	// ------------------------------------------------------------------------
	// Report side
	// ------------------------------------------------------------------------

	// Draws a stall before every report, holds tready low for it, and checks
	// each report against the oldest expectation.
	initial begin : report_sink
		report_t seen;
		report_t want;
		int      stall;
		bit      bad;
		int      i;
		wait (arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			seen = '{mods: m_tdata[7:0], keys: m_tdata[55:8], sent: m_tuser[0],
				ok: m_tuser[1], last: m_tlast};
			reports_seen++;
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("report %0d arrived with none expected: mods %h keys %h",
						reports_seen, seen.mods, seen.keys);
			end else begin
				want = pending_reports.pop_front();
				bad  = (seen.mods !== want.mods) || (seen.sent !== want.sent) ||
					(seen.ok !== want.ok) || (seen.last !== want.last);
				for (i = 0; i < NUM_SLOTS; i++)
					if (seen.keys[i] !== want.keys[i])
						bad = 1'b1;
				if (bad) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("report %0d expected mods %h keys %h sent %b ok %b last %b",
							reports_seen, want.mods, want.keys, want.sent, want.ok,
							want.last);
						$display("report %0d      got mods %h keys %h sent %b ok %b last %b",
							reports_seen, seen.mods, seen.keys, seen.sent, seen.ok,
							seen.last);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: counts cycles in which neither side completes a request.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		func_t      f;
		logic [7:0] code;
		int         n;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		m_tready    = 1'b0;
		mod_state   = 8'h00;
		key_state   = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A typed row replaces the model's single report with
		// the one written in the table; the model still tracks the state.
		for (n = 0; n < NUM_DIRECTED; n++) begin
			send_event(DIRECTED[n].f, DIRECTED[n].code);
			if (DIRECTED[n].typed)
				pending_reports[pending_reports.size() - 1] = DIRECTED[n].want;
		end

		repeat (RANDOM_EVENTS) begin
			draw_event(f, code);
			send_event(f, code);
		end
		s_tvalid <= 1'b0;

		// Let every expected report drain, then give the block a few more
		// cycles to show any report that should not be there.
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
